// ===== rtl/base64_line_wrap_encoder_defines.svh =====
// Assertion macros shared by the encoder modules.
`ifndef BASE64_LINE_WRAP_ENCODER_DEFINES_SVH
`define BASE64_LINE_WRAP_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64LW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("b64lw assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define B64LW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("b64lw assertion failed");

`endif

// ===== rtl/b64lw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package b64lw_pkg;

	localparam int LINE_BYTES = 57;
	localparam int LINE_CNT_W = 7;
	localparam int MAX_CHARS = 5;
	localparam int CNT_W = 3;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CHAR_PAD = 8'h3D;
	localparam logic [7:0] CHAR_NL = 8'h0A;

	typedef enum logic [1:0] {
		PHASE_0 = 2'd0,
		PHASE_1 = 2'd1,
		PHASE_2 = 2'd2
	} phase_t;

	// One input byte's worth of output characters.
	typedef struct packed {
		logic [MAX_CHARS-1:0][7:0] chars;
		logic [CNT_W-1:0]          count;
		logic                      fin;
	} job_t;

	function automatic logic [7:0] sym(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26) begin
			r = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			r = 8'h61 + {2'b00, v - 6'd26};
		end else if (v < 6'd62) begin
			r = 8'h30 + {2'b00, v - 6'd52};
		end else if (v == 6'd62) begin
			r = 8'h2B;
		end else begin
			r = 8'h2F;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/b64lw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "base64_line_wrap_encoder_defines.svh"
module b64lw_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wrap_en,
	input  wire logic           push,
	input  wire logic [7:0]     data_byte,
	input  wire logic           final_byte,
	output b64lw_pkg::job_t     job
);

	b64lw_pkg::phase_t                   phase_q, phase_d;
	logic [3:0]                          carry_q, carry_d;
	logic [b64lw_pkg::LINE_CNT_W-1:0]    line_cnt_q, line_cnt_d, cnt_inc;

	always_comb begin
		cnt_inc = line_cnt_q + 1'b1;
		line_cnt_d = cnt_inc;
		phase_d = phase_q;
		carry_d = carry_q;
		job = '0;
		job.fin = final_byte;
		case (phase_q)
			b64lw_pkg::PHASE_1: begin
				job.chars[0] = b64lw_pkg::sym({carry_q[1:0], data_byte[7:4]});
				job.count = 3'd1;
				carry_d = data_byte[3:0];
				phase_d = b64lw_pkg::PHASE_2;
				if (final_byte) begin
					job.chars[1] = b64lw_pkg::sym({data_byte[3:0], 2'b00});
					job.chars[2] = b64lw_pkg::CHAR_PAD;
					job.chars[3] = b64lw_pkg::CHAR_NL;
					job.count = wrap_en ? 3'd4 : 3'd3;
				end
			end
			b64lw_pkg::PHASE_2: begin
				job.chars[0] = b64lw_pkg::sym({carry_q, data_byte[7:6]});
				job.chars[1] = b64lw_pkg::sym(data_byte[5:0]);
				job.chars[2] = b64lw_pkg::CHAR_NL;
				job.count = 3'd2;
				carry_d = 4'd0;
				phase_d = b64lw_pkg::PHASE_0;
				if (cnt_inc >= b64lw_pkg::LINE_CNT_W'(b64lw_pkg::LINE_BYTES)) begin
					line_cnt_d = '0;
					if (wrap_en) begin
						job.count = 3'd3;
					end
				end else if (final_byte && wrap_en) begin
					job.count = 3'd3;
				end
			end
			default: begin
				job.chars[0] = b64lw_pkg::sym(data_byte[7:2]);
				job.count = 3'd1;
				carry_d = {2'b00, data_byte[1:0]};
				phase_d = b64lw_pkg::PHASE_1;
				if (final_byte) begin
					job.chars[1] = b64lw_pkg::sym({data_byte[1:0], 4'b0000});
					job.chars[2] = b64lw_pkg::CHAR_PAD;
					job.chars[3] = b64lw_pkg::CHAR_PAD;
					job.chars[4] = b64lw_pkg::CHAR_NL;
					job.count = wrap_en ? 3'd5 : 3'd4;
				end
			end
		endcase
		if (final_byte) begin
			phase_d = b64lw_pkg::PHASE_0;
			carry_d = 4'd0;
			line_cnt_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= b64lw_pkg::PHASE_0;
			carry_q <= 4'd0;
			line_cnt_q <= '0;
		end else if (push) begin
			phase_q <= phase_d;
			carry_q <= carry_d;
			line_cnt_q <= line_cnt_d;
		end
	end

	`B64LW_ASSERT_NEXT(a_fin_clears, clk, arst_n, push && final_byte,
		phase_q == b64lw_pkg::PHASE_0 && carry_q == 4'd0 && line_cnt_q == '0)
	`B64LW_ASSERT_NOW(a_line_bound, clk, arst_n, 1'b1,
		line_cnt_q < b64lw_pkg::LINE_CNT_W'(b64lw_pkg::LINE_BYTES + 2))
	`B64LW_ASSERT_NOW(a_count_range, clk, arst_n, push,
		job.count != 3'd0 && job.count <= 3'd5)

endmodule
`default_nettype wire

// ===== rtl/b64lw_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "base64_line_wrap_encoder_defines.svh"
module b64lw_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire b64lw_pkg::job_t wr_job,
	input  wire logic           pop,
	output b64lw_pkg::job_t     rd_job,
	output logic                full,
	output logic                empty
);

	b64lw_pkg::job_t                   mem_q [b64lw_pkg::QDEPTH];
	logic [b64lw_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [b64lw_pkg::QCNT_W-1:0]      count_q;

	assign full = count_q == b64lw_pkg::QCNT_W'(b64lw_pkg::QDEPTH);
	assign empty = count_q == '0;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == b64lw_pkg::QPTR_W'(b64lw_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == b64lw_pkg::QPTR_W'(b64lw_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`B64LW_ASSERT_NOW(a_no_overflow, clk, arst_n, 1'b1,
		count_q <= b64lw_pkg::QCNT_W'(b64lw_pkg::QDEPTH))
	`B64LW_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, !empty)
	`B64LW_ASSERT_NEXT(a_push_lands, clk, arst_n, push && !pop && !full, !empty)

endmodule
`default_nettype wire

// ===== rtl/b64lw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "base64_line_wrap_encoder_defines.svh"
module b64lw_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire b64lw_pkg::job_t head,
	input  wire logic           head_valid,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [7:0]          out_char,
	output logic                run_last,
	output logic                message_end
);

	logic [b64lw_pkg::CNT_W-1:0] idx_q;
	logic                        out_valid_q, run_last_q, message_end_q;
	logic [7:0]                  out_char_q;
	logic                        load, take, last;

	assign load = !out_valid_q || !out_stall;
	assign take = load && head_valid;
	assign last = idx_q == head.count - 1'b1;
	assign pop = take && last;

	assign out_valid = out_valid_q;
	assign out_char = out_char_q;
	assign run_last = run_last_q;
	assign message_end = message_end_q;

	always_ff @(posedge clk) begin
		if (take) begin
			out_char_q <= head.chars[idx_q];
			run_last_q <= last;
			message_end_q <= last && head.fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				out_valid_q <= head_valid;
			end
			if (take) begin
				idx_q <= last ? '0 : idx_q + 1'b1;
			end
		end
	end

	`B64LW_ASSERT_NOW(a_idx_in_job, clk, arst_n, head_valid, idx_q < head.count)
	`B64LW_ASSERT_NOW(a_end_is_last, clk, arst_n, out_valid_q && message_end_q, run_last_q)
	`B64LW_ASSERT_NEXT(a_idx_restart, clk, arst_n, pop, idx_q == '0)

endmodule
`default_nettype wire

// ===== rtl/base64_line_wrap_encoder.sv =====
// Each byte's characters pass through the job queue and the output register before they are offered.
// Throughput: one character per cycle while out_stall is low; a byte yields one to five
// characters, four for every three bytes on average, a little more with newlines.
// A two-entry queue lets input beats continue while the output side is stalled.
// Reset (arst_n low, asynchronous): group state cleared, queue empty, wrap off.
`timescale 1ns / 1ps
`default_nettype none
module base64_line_wrap_encoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic       cfg_wr_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_char,
	output logic            run_last,
	output logic            message_end
);

	logic            wrap_enable_q;
	logic            push, pop, full, empty;
	b64lw_pkg::job_t wr_job, rd_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			wrap_enable_q <= cfg_wr_data;
		end
	end

	assign in_stall = full;
	assign push = in_valid && !full;

	b64lw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.wrap_en    (wrap_enable_q),
		.push       (push),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.job        (wr_job)
	);

	b64lw_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.pop    (pop),
		.rd_job (rd_job),
		.full   (full),
		.empty  (empty)
	);

	b64lw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (rd_job),
		.head_valid  (!empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.run_last    (run_last),
		.message_end (message_end)
	);

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES = 10;
	localparam logic [511:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       msg_end;
	} enc_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic       cfg_wr_data = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] data_byte = 8'h00;
	logic       final_byte = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_char;
	logic       run_last;
	logic       message_end;

	enc_char_t          expected_chars[$];
	logic               wrap_on = 1'b0;
	b64lw_pkg::phase_t  grp_phase = b64lw_pkg::PHASE_0;
	logic [3:0]         carry = 4'h0;
	logic [6:0]         line_cnt = 7'd0;
	int                 send_idle_pct = 0;
	int                 stall_pct = 0;
	int                 bytes_sent = 0;
	int                 errors = 0;
	int                 quiet_cycles = 0;

	base64_line_wrap_encoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.final_byte  (final_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_char    (out_char),
		.run_last    (run_last),
		.message_end (message_end)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		return B64_ALPHABET[8 * (63 - int'(v)) +: 8];
	endfunction

	// Works out the characters one accepted byte produces and updates the group state.
	task automatic encode_byte(input logic [7:0] b, input logic fin);
		logic [7:0] run[$];
		enc_char_t  c;
		run = {};
		line_cnt = line_cnt + 7'd1;
		case (grp_phase)
			b64lw_pkg::PHASE_1: begin
				run = {run, b64_char({carry[1:0], b[7:4]})};
				carry = b[3:0];
				grp_phase = b64lw_pkg::PHASE_2;
				if (fin) begin
					run = {run, b64_char({carry, 2'b00})};
					run = {run, b64lw_pkg::CHAR_PAD};
					if (wrap_on)
						run = {run, b64lw_pkg::CHAR_NL};
				end
			end
			b64lw_pkg::PHASE_2: begin
				run = {run, b64_char({carry, b[7:6]})};
				run = {run, b64_char(b[5:0])};
				carry = 4'h0;
				grp_phase = b64lw_pkg::PHASE_0;
				if (int'(line_cnt) >= b64lw_pkg::LINE_BYTES) begin
					line_cnt = 7'd0;
					if (wrap_on)
						run = {run, b64lw_pkg::CHAR_NL};
				end else if (fin && wrap_on) begin
					run = {run, b64lw_pkg::CHAR_NL};
				end
			end
			default: begin
				run = {run, b64_char(b[7:2])};
				carry = {2'b00, b[1:0]};
				grp_phase = b64lw_pkg::PHASE_1;
				if (fin) begin
					run = {run, b64_char({b[1:0], 4'h0})};
					run = {run, b64lw_pkg::CHAR_PAD};
					run = {run, b64lw_pkg::CHAR_PAD};
					if (wrap_on)
						run = {run, b64lw_pkg::CHAR_NL};
				end
			end
		endcase
		for (int i = 0; i < run.size(); i++) begin
			c.ch = run[i];
			c.last = (i == run.size() - 1);
			c.msg_end = fin && c.last;
			expected_chars = {expected_chars, c};
		end
		if (fin) begin
			grp_phase = b64lw_pkg::PHASE_0;
			carry = 4'h0;
			line_cnt = 7'd0;
		end
	endtask

	always @(posedge clk) begin
		enc_char_t exp_c;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_chars.size() == 0) begin
				$error("out_char: expected nothing, actual %h", out_char);
				errors++;
			end else begin
				exp_c = expected_chars.pop_front();
				if (out_char !== exp_c.ch) begin
					$error("out_char: expected %h, actual %h", exp_c.ch, out_char);
					errors++;
				end
				if (run_last !== exp_c.last) begin
					$error("run_last: expected %b, actual %b", exp_c.last, run_last);
					errors++;
				end
				if (message_end !== exp_c.msg_end) begin
					$error("message_end: expected %b, actual %b", exp_c.msg_end,
						message_end);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic apply_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// Valid stays high after a beat; only the next idle cycle or a drain lowers it.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		final_byte <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		encode_byte(b, fin);
		bytes_sent++;
	endtask

	task automatic drain_encoder();
		in_valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_wrap(input logic v);
		drain_encoder();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		wrap_on = v;
	endtask

	task automatic send_message(input int len, input int early_pct);
		logic fin;
		for (int i = 0; i < len; i++) begin
			fin = (i == len - 1) || ($urandom_range(99) < early_pct);
			send_byte(8'($urandom_range(255)), fin);
			if (fin)
				break;
		end
	endtask

	task automatic test_short_messages();
		write_wrap(1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h4D, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h6E, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic test_closing_newline();
		write_wrap(1'b1);
		send_byte(8'h01, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_byte(8'hFB, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBE, 1'b1);
	endtask

	task automatic test_wrap_toggle();
		write_wrap(1'b1);
		send_byte(8'h10, 1'b0);
		send_byte(8'h20, 1'b0);
		write_wrap(1'b0);
		send_byte(8'h30, 1'b1);
		send_byte(8'h40, 1'b0);
		write_wrap(1'b1);
		send_byte(8'h50, 1'b1);
	endtask

	task automatic test_line_lengths();
		write_wrap(1'b1);
		send_idle_pct = 10;
		stall_pct = 10;
		send_message(b64lw_pkg::LINE_BYTES, 0);
		send_message(b64lw_pkg::LINE_BYTES + 1, 0);
	endtask

	task automatic test_random_traffic(input int n_bytes, input int idle_pct,
		input int stall_in, input logic wrap);
		int first_idx;
		int pick;
		int len;
		int left;
		write_wrap(wrap);
		send_idle_pct = idle_pct;
		stall_pct = stall_in;
		first_idx = bytes_sent;
		while (bytes_sent - first_idx < n_bytes) begin
			left = n_bytes - (bytes_sent - first_idx);
			pick = int'($urandom_range(99));
			if (pick < 10)
				len = int'($urandom_range(125, 110));
			else if (pick < 25)
				len = int'($urandom_range(62, 54));
			else
				len = int'($urandom_range(16, 1));
			if (len > left)
				len = left;
			send_message(len, (pick < 25) ? 0 : 3);
		end
	endtask

	initial begin
		apply_reset();
		test_short_messages();
		test_closing_newline();
		test_wrap_toggle();
		test_line_lengths();
		test_random_traffic(78, 0, 0, 1'b0);
		test_random_traffic(78, 66, 0, 1'b1);
		test_random_traffic(78, 0, 66, 1'b0);
		test_random_traffic(78, 10, 10, 1'b1);
		drain_encoder();
		stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/b64lw_pkg.sv
rtl/b64lw_front.sv
rtl/b64lw_fifo.sv
rtl/b64lw_back.sv
rtl/base64_line_wrap_encoder.sv
sim/tb.sv
